/* hdl/bbm_pkg.sv */
// Shared types, constants and register indexes for the ball motion step block.
// Used by bbm_alu, bbm_seq and ball_bounce_motion_step_top. No dependencies.
package bbm_pkg;

	// Fixed point formats
	localparam int DIR_FRAC_BITS = 14;
	localparam int POS_FRAC_BITS = 8;

	// Field widths
	localparam int POS_W  = 21;
	localparam int DIR_W  = 16;
	localparam int WW_W   = 12;
	localparam int DIA_W  = 10;
	localparam int SPD_W  = 20;
	localparam int DT_W   = 16;
	localparam int MODE_W = 2;

	// Stream and register port widths
	localparam int IN_DATA_W  = 128;
	localparam int OUT_DATA_W = 80;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// Shared unit operand widths
	localparam int MUL_A_W = 36;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int SUB_W   = 62;

	// Direction limits
	localparam logic signed [DIR_W-1:0] DIR_MAX = 16'sh7FFF;
	localparam logic signed [DIR_W-1:0] DIR_MIN = 16'sh8000;
	localparam logic signed [DIR_W-1:0] DIR_ONE = DIR_W'(1 << DIR_FRAC_BITS);

	// Register reset values
	localparam logic [WW_W-1:0]  WIDTH_RST  = 12'd800;
	localparam logic [WW_W-1:0]  HEIGHT_RST = 12'd600;
	localparam logic [DIA_W-1:0] DIA_RST    = 10'd42;
	localparam logic [SPD_W-1:0] SPEED_RST  = 20'd30720;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIAM   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 2'd3;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK    = 2'd0,
		MODE_COLLIDE = 2'd1,
		MODE_PLACE   = 2'd2
	} mode_t;

	typedef struct packed {
		logic [WW_W-1:0]  width;
		logic [WW_W-1:0]  height;
		logic [DIA_W-1:0] diam;
		logic [SPD_W-1:0] speed;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic [DT_W-1:0]          dt;
		logic signed [DIR_W-1:0]  nx;
		logic signed [DIR_W-1:0]  ny;
		logic signed [POS_W-1:0]  px;
		logic signed [POS_W-1:0]  py;
		logic signed [DIR_W-1:0]  pdx;
		logic signed [DIR_W-1:0]  pdy;
	} item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
	} ball_t;

	typedef struct packed {
		logic [MUL_A_W-1:0] mul_a;
		logic [MUL_B_W-1:0] mul_b;
		logic [SUB_W-1:0]   sub_a;
		logic [SUB_W-1:0]   sub_b;
	} alu_req_t;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic [SUB_W-1:0]  diff;
		logic              borrow;
	} alu_rsp_t;

endpackage

/* hdl/bbm_alu.sv */
// Shared arithmetic unit: one unsigned 36x18 multiplier and one 62 bit subtractor.
// Depends on bbm_pkg. The sequencer registers every result.
module bbm_alu (
	input  bbm_pkg::alu_req_t req,
	output bbm_pkg::alu_rsp_t rsp
);
	import bbm_pkg::*;

	logic [SUB_W:0] sub_full;

	// Multiply
	assign rsp.prod = req.mul_a * req.mul_b;

	// Subtract with borrow out, used as compare for root and divide steps
	assign sub_full   = {1'b0, req.sub_a} - {1'b0, req.sub_b};
	assign rsp.diff   = sub_full[SUB_W-1:0];
	assign rsp.borrow = sub_full[SUB_W];

endmodule

/* hdl/bbm_seq.sv */
// Ball state and the sequencer that drives the shared arithmetic unit.
// Depends on bbm_pkg and bbm_alu. Runs tick, reflect/renormalize and place items.
module bbm_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bbm_pkg::item_t item,
	input  bbm_pkg::cfg_t  cfg,
	input  logic           done_take,
	output logic           idle,
	output logic           done_valid,
	output bbm_pkg::ball_t ball
);
	import bbm_pkg::*;

	localparam int MOVE_SH  = DIR_FRAC_BITS + DT_W;
	localparam int MOVE_Q_W = 23;
	localparam int REFL_SH  = 2 * DIR_FRAC_BITS;
	localparam int R_W      = 50;
	localparam int A_W      = R_W - 1;
	localparam int NORM_LIM = 30;
	localparam int LEN_W    = NORM_LIM + 1;
	localparam int REM_W    = 46;
	localparam int Q_W      = DIR_FRAC_BITS + 1;
	localparam logic [4:0] ROOT_K0 = 5'(NORM_LIM);
	localparam logic [4:0] DIV_K0  = 5'(DIR_FRAC_BITS);
	localparam logic [SUB_W-1:0] ROUND_HALF = SUB_W'(1) << (MOVE_SH - 1);

	typedef enum logic [17:0] {
		S_IDLE = 18'h00001,
		S_WALL = 18'h00002,
		S_MUL1 = 18'h00004,
		S_MUL2 = 18'h00008,
		S_RND  = 18'h00010,
		S_MOVE = 18'h00020,
		S_DOT1 = 18'h00040,
		S_DOT2 = 18'h00080,
		S_DABS = 18'h00100,
		S_REFL = 18'h00200,
		S_RADD = 18'h00400,
		S_MAG  = 18'h00800,
		S_NORM = 18'h01000,
		S_SQR  = 18'h02000,
		S_ROOT = 18'h04000,
		S_DIVI = 18'h08000,
		S_DIV  = 18'h10000,
		S_DONE = 18'h20000
	} state_t;

	state_t state_q;
	logic   axis_q;
	logic [4:0] cnt_q;

	logic [DT_W-1:0]         dt_q;
	logic signed [DIR_W-1:0] nx_q, ny_q;
	logic signed [POS_W-1:0] pos_x_q, pos_y_q;
	logic signed [DIR_W-1:0] dir_x_q, dir_y_q;

	logic [SUB_W-1:0] acc_q;
	logic [32:0]      dot_q;
	logic [31:0]      dmag_q;
	logic             dneg_q;
	logic [R_W-1:0]   rx_q, ry_q;
	logic [A_W-1:0]   ax_q, ay_q;
	logic             sx_q, sy_q;
	logic [SUB_W-1:0] res_q;
	logic [REM_W-1:0] rem_q;
	logic [Q_W-2:0]   quot_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	function automatic logic [DIR_W-1:0] mag16(input logic signed [DIR_W-1:0] v);
		mag16 = v[DIR_W-1] ? DIR_W'(-v) : DIR_W'(v);
	endfunction

	function automatic logic signed [DIR_W-1:0] neg_dir(input logic signed [DIR_W-1:0] d);
		neg_dir = (d == DIR_MIN) ? DIR_MAX : -d;
	endfunction

	bbm_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Axis selection
	logic signed [POS_W-1:0] cur_pos;
	logic signed [DIR_W-1:0] cur_dir, cur_n;
	logic [A_W-1:0]          cur_a, cur_sq;
	logic                    cur_s;

	assign cur_pos = axis_q ? pos_y_q : pos_x_q;
	assign cur_dir = axis_q ? dir_y_q : dir_x_q;
	assign cur_n   = axis_q ? ny_q : nx_q;
	assign cur_a   = axis_q ? ay_q : ax_q;
	assign cur_s   = axis_q ? sy_q : sx_q;
	assign cur_sq  = cnt_q[1] ? ay_q : ax_q;

	// Wall test: signed limit in position units
	logic signed [WW_W:0]    lim_w, lim_h;
	logic signed [POS_W-1:0] lim_x, lim_y;
	logic                    hit_x, hit_y;

	assign lim_w = $signed({1'b0, cfg.width})  - $signed({3'b000, cfg.diam});
	assign lim_h = $signed({1'b0, cfg.height}) - $signed({3'b000, cfg.diam});
	assign lim_x = {lim_w, POS_FRAC_BITS'(0)};
	assign lim_y = {lim_h, POS_FRAC_BITS'(0)};
	assign hit_x = (pos_x_q > lim_x) || pos_x_q[POS_W-1];
	assign hit_y = (pos_y_q > lim_y) || pos_y_q[POS_W-1];

	// Move: rounded displacement added with saturation
	logic [MOVE_Q_W-1:0]       mv_q;
	logic signed [POS_W+3:0]   mv_disp, mv_sum;
	logic signed [POS_W-1:0]   mv_new;

	assign mv_q    = acc_q[MOVE_SH +: MOVE_Q_W];
	assign mv_disp = cur_dir[DIR_W-1] ? -$signed({2'b00, mv_q}) : $signed({2'b00, mv_q});
	assign mv_sum  = $signed({{4{cur_pos[POS_W-1]}}, cur_pos}) + mv_disp;
	always_comb begin
		if (mv_sum[POS_W+3:POS_W-1] != {5{mv_sum[POS_W+3]}}) begin
			mv_new = mv_sum[POS_W+3] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end else begin
			mv_new = mv_sum[POS_W-1:0];
		end
	end

	// Dot product term, sign-magnitude product to two's complement
	logic [31:0] dot_p;
	logic        dot_neg;
	logic [32:0] dot_add;
	logic [32:0] dot_abs;

	assign dot_p   = alu_rsp.prod[31:0];
	assign dot_neg = axis_q ? (dir_y_q[DIR_W-1] ^ ny_q[DIR_W-1])
	                        : (dir_x_q[DIR_W-1] ^ nx_q[DIR_W-1]);
	assign dot_add = dot_neg ? -{1'b0, dot_p} : {1'b0, dot_p};
	assign dot_abs = -dot_q;

	// Reflected component: d*2^28 -/+ 2*|dot*n|
	logic [R_W-1:0] refl_d, refl_t, refl_r;

	assign refl_d = {{(R_W-DIR_W-REFL_SH){cur_dir[DIR_W-1]}}, cur_dir, REFL_SH'(0)};
	assign refl_t = {1'b0, acc_q[47:0], 1'b0};
	assign refl_r = (dneg_q ^ cur_n[DIR_W-1]) ? refl_d + refl_t : refl_d - refl_t;

	logic [R_W-1:0] nrx, nry;
	assign nrx = -rx_q;
	assign nry = -ry_q;

	// Normalize: either component at or above 2^30 forces a right shift
	logic [A_W-1:0] norm_or;
	assign norm_or = ax_q | ay_q;

	// Sum of squares in four partial products
	logic [SUB_W-1:0] sq_add;
	assign sq_add = cnt_q[0] ? (SUB_W'(alu_rsp.prod) << MUL_B_W) : SUB_W'(alu_rsp.prod);

	// Root step: res is always aligned so add is an OR
	logic [SUB_W-1:0] root_bit, root_mask, res_nx;
	assign root_bit  = SUB_W'(1) << {cnt_q, 1'b0};
	assign root_mask = {root_bit[SUB_W-3:0], 2'b00} - SUB_W'(1);
	assign res_nx    = alu_rsp.borrow ? (res_q >> 1) : ((res_q >> 1) | root_bit);

	// Divide step
	logic [Q_W-1:0]   div_q_fin;
	logic [DIR_W-1:0] div_dir;
	assign div_q_fin = {quot_q, ~alu_rsp.borrow};
	assign div_dir   = cur_s ? -{1'b0, div_q_fin} : {1'b0, div_q_fin};

	// Shared unit operand select
	always_comb begin
		alu_req = '0;
		case (state_q)
			S_MUL1: begin
				alu_req.mul_a = MUL_A_W'(cfg.speed);
				alu_req.mul_b = MUL_B_W'(mag16(cur_dir));
			end
			S_MUL2: begin
				alu_req.mul_a = acc_q[MUL_A_W-1:0];
				alu_req.mul_b = MUL_B_W'(dt_q);
			end
			S_DOT1, S_DOT2: begin
				alu_req.mul_a = MUL_A_W'(mag16(cur_dir));
				alu_req.mul_b = MUL_B_W'(mag16(cur_n));
			end
			S_REFL: begin
				alu_req.mul_a = MUL_A_W'(dmag_q);
				alu_req.mul_b = MUL_B_W'(mag16(cur_n));
			end
			S_SQR: begin
				alu_req.mul_a = MUL_A_W'(cur_sq[NORM_LIM-1:0]);
				alu_req.mul_b = cnt_q[0] ? MUL_B_W'(cur_sq[NORM_LIM-1:MUL_B_W])
				                         : cur_sq[MUL_B_W-1:0];
			end
			S_ROOT: begin
				alu_req.sub_a = acc_q;
				alu_req.sub_b = res_q | root_bit;
			end
			S_DIV: begin
				alu_req.sub_a = SUB_W'(rem_q);
				alu_req.sub_b = SUB_W'(res_q[LEN_W-1:0]) << cnt_q;
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	// Control and ball state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q  <= 1'b0;
			cnt_q   <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			dir_x_q <= DIR_ONE;
			dir_y_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					axis_q <= 1'b0;
					if (start) begin
						case (mode_t'(item.mode))
							MODE_TICK:    state_q <= S_WALL;
							MODE_COLLIDE: state_q <= S_DOT1;
							MODE_PLACE: begin
								pos_x_q <= item.px;
								pos_y_q <= item.py;
								dir_x_q <= item.pdx;
								dir_y_q <= item.pdy;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_WALL: begin
					if (hit_x) dir_x_q <= neg_dir(dir_x_q);
					if (hit_y) dir_y_q <= neg_dir(dir_y_q);
					state_q <= S_MUL1;
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_RND;
				S_RND:  state_q <= S_MOVE;
				S_MOVE: begin
					if (axis_q) begin
						pos_y_q <= mv_new;
						state_q <= S_DONE;
					end else begin
						pos_x_q <= mv_new;
						axis_q  <= 1'b1;
						state_q <= S_MUL1;
					end
				end
				S_DOT1: begin
					axis_q  <= 1'b1;
					state_q <= S_DOT2;
				end
				S_DOT2: begin
					axis_q  <= 1'b0;
					state_q <= S_DABS;
				end
				S_DABS: state_q <= S_REFL;
				S_REFL: state_q <= S_RADD;
				S_RADD: begin
					axis_q  <= ~axis_q;
					state_q <= axis_q ? S_MAG : S_REFL;
				end
				S_MAG: state_q <= S_NORM;
				S_NORM: begin
					if (norm_or[A_W-1:NORM_LIM] == '0) begin
						cnt_q   <= '0;
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q[1:0] == 2'd3) begin
						cnt_q   <= ROOT_K0;
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						axis_q  <= 1'b0;
						state_q <= (res_nx == '0) ? S_DONE : S_DIVI;
					end
				end
				S_DIVI: begin
					cnt_q   <= DIV_K0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						if (axis_q) begin
							dir_y_q <= div_dir;
							state_q <= S_DONE;
						end else begin
							dir_x_q <= div_dir;
							axis_q  <= 1'b1;
							state_q <= S_DIVI;
						end
					end
				end
				S_DONE: begin
					if (done_take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					dt_q <= item.dt;
					nx_q <= item.nx;
					ny_q <= item.ny;
				end
			end
			S_MUL1, S_MUL2, S_REFL: acc_q <= SUB_W'(alu_rsp.prod);
			S_RND:  acc_q <= acc_q + ROUND_HALF;
			S_DOT1: dot_q <= dot_add;
			S_DOT2: dot_q <= dot_q + dot_add;
			S_DABS: begin
				dneg_q <= dot_q[32];
				dmag_q <= dot_q[32] ? dot_abs[31:0] : dot_q[31:0];
			end
			S_RADD: begin
				if (axis_q) ry_q <= refl_r;
				else        rx_q <= refl_r;
			end
			S_MAG: begin
				sx_q <= rx_q[R_W-1];
				sy_q <= ry_q[R_W-1];
				ax_q <= rx_q[R_W-1] ? nrx[A_W-1:0] : rx_q[A_W-1:0];
				ay_q <= ry_q[R_W-1] ? nry[A_W-1:0] : ry_q[A_W-1:0];
			end
			S_NORM: begin
				if (norm_or[A_W-1:NORM_LIM+4] != '0) begin
					ax_q <= ax_q >> 4;
					ay_q <= ay_q >> 4;
				end else if (norm_or[NORM_LIM+3:NORM_LIM] != '0) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
				end
				res_q <= '0;
			end
			S_SQR: acc_q <= ((cnt_q[1:0] == 2'd0) ? '0 : acc_q) + sq_add;
			S_ROOT: begin
				if (!alu_rsp.borrow) acc_q <= alu_rsp.diff;
				res_q <= res_nx;
			end
			S_DIVI: begin
				rem_q  <= REM_W'({cur_a[NORM_LIM-1:0], DIR_FRAC_BITS'(0)})
				        + REM_W'(res_q[LEN_W-1:1]);
				quot_q <= '0;
			end
			S_DIV: begin
				if (!alu_rsp.borrow) rem_q <= alu_rsp.diff[REM_W-1:0];
				quot_q <= div_q_fin[Q_W-2:0];
			end
			default: begin
			end
		endcase
	end

	assign idle        = (state_q == S_IDLE);
	assign done_valid  = (state_q == S_DONE);
	assign ball.pos_x  = pos_x_q;
	assign ball.pos_y  = pos_y_q;
	assign ball.dir_x  = dir_x_q;
	assign ball.dir_y  = dir_y_q;

	// Checks
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == S_IDLE)
		else $error("item started while sequencer busy");

	a_root_align: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROOT |-> (res_q & root_mask) == '0)
		else $error("root partial result not aligned to step bit");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQR |-> (ax_q[A_W-1:NORM_LIM] == '0 && ay_q[A_W-1:NORM_LIM] == '0))
		else $error("reflected vector not normalized before squaring");

	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == '0) |-> div_q_fin <= Q_W'(DIR_ONE))
		else $error("renormalized component above unit length");

endmodule

/* hdl/ball_bounce_motion_step_top.sv */
// Top level of the ball motion step block: stream ports, register file, result register.
// Depends on bbm_pkg and bbm_seq (which holds bbm_alu).
//
// Usage:
// Input channel s_*: one transaction is one item; s_tuser carries the mode
// (tick, collision, place). Output channel m_*: one result transaction per
// item with the ball position and heading after the step.
// Registers are written through wr_en / wr_index / wr_data while the block
// is idle (user rule, not enforced); a write takes effect at the next clock edge.
// A collision runs a 31 step square root and, unless the reflected vector has
// zero length, two 15 step divides, all on the one shared subtractor.
// One item is in work at a time; s_tready is high only while the sequencer is
// idle. A finished result waits in the output register, so the next item is
// taken while m_tready is low; a second result then holds the sequencer
// until the output register drains.
// Reset: position 0,0, heading (1.0, 0), registers at their defaults.
module ball_bounce_motion_step_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// input items
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// delta_time, normal_x, normal_y, place_x, place_y, place_dir_x, place_dir_y, pad
	input  logic [bbm_pkg::IN_DATA_W-1:0]    s_tdata,
	// mode
	input  logic [bbm_pkg::MODE_W-1:0]       s_tuser,
	// results
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// position_x, position_y, heading_x, heading_y, pad
	output logic [bbm_pkg::OUT_DATA_W-1:0]   m_tdata,
	// register writes
	input  logic                             wr_en,
	input  logic [bbm_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [bbm_pkg::CFG_DATA_W-1:0]   wr_data
);
	import bbm_pkg::*;

	cfg_t  cfg_q;
	item_t item;
	ball_t ball;
	logic  seq_idle, seq_done, take, start;
	logic  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= WIDTH_RST;
			cfg_q.height <= HEIGHT_RST;
			cfg_q.diam   <= DIA_RST;
			cfg_q.speed  <= SPEED_RST;
		end else if (wr_en) begin
			case (wr_index)
				CFG_WIDTH:  cfg_q.width  <= wr_data[WW_W-1:0];
				CFG_HEIGHT: cfg_q.height <= wr_data[WW_W-1:0];
				CFG_DIAM:   cfg_q.diam   <= wr_data[DIA_W-1:0];
				CFG_SPEED:  cfg_q.speed  <= wr_data[SPD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input unpacking
	assign item.mode = s_tuser;
	assign item.dt   = s_tdata[15:0];
	assign item.nx   = s_tdata[31:16];
	assign item.ny   = s_tdata[47:32];
	assign item.px   = s_tdata[68:48];
	assign item.py   = s_tdata[89:69];
	assign item.pdx  = s_tdata[105:90];
	assign item.pdy  = s_tdata[121:106];

	assign s_tready = seq_idle;
	assign start    = s_tvalid && seq_idle;

	bbm_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.cfg        (cfg_q),
		.done_take  (take),
		.idle       (seq_idle),
		.done_valid (seq_done),
		.ball       (ball)
	);

	// Output register
	assign take = seq_done && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_data_q <= {6'b000000, ball.dir_y, ball.dir_x, ball.pos_y, ball.pos_x};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
